// ===== rtl/ppp_pkg.sv =====
package ppp_pkg;

    localparam int COORD_W  = 16;
    localparam int ROT_W    = 16;
    localparam int FOCAL_W  = 16;
    localparam int HALF_W   = 12;
    localparam int PIX_W    = 32;
    localparam int DEPTH_W  = 24;
    localparam int CFG_W    = 48;
    localparam int D_W      = COORD_W + 1;
    localparam int PROD_W   = ROT_W + D_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int FRAC_SH  = 14;
    localparam int CAM_W    = ACC_W - FRAC_SH;
    localparam int NUM_W    = FOCAL_W + 1 + CAM_W + 4;
    localparam int MAG_W    = NUM_W - 1;
    localparam int DEN_W    = CAM_W;
    localparam int SUM_W    = MAG_W + 2;
    localparam int IDX_W    = 3;

    typedef enum logic [IDX_W-1:0] {
        CFG_ROT_ROW_0   = 3'd0,
        CFG_ROT_ROW_1   = 3'd1,
        CFG_ROT_ROW_2   = 3'd2,
        CFG_CAM_CENTER  = 3'd3,
        CFG_FOCAL_X     = 3'd4,
        CFG_FOCAL_Y     = 3'd5,
        CFG_HALF_WIDTH  = 3'd6,
        CFG_HALF_HEIGHT = 3'd7
    } t_ppp_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_ppp_point;

    typedef struct packed {
        logic signed [PIX_W-1:0]   pixel_x;
        logic signed [PIX_W-1:0]   pixel_y;
        logic signed [DEPTH_W-1:0] depth;
        logic                      zero_depth;
    } t_ppp_result;

    typedef struct packed {
        logic [CFG_W-1:0]   rot_row_0;
        logic [CFG_W-1:0]   rot_row_1;
        logic [CFG_W-1:0]   rot_row_2;
        logic [CFG_W-1:0]   cam_center;
        logic [FOCAL_W-1:0] focal_x;
        logic [FOCAL_W-1:0] focal_y;
        logic [HALF_W-1:0]  half_width;
        logic [HALF_W-1:0]  half_height;
    } t_ppp_cfg;

    typedef struct packed {
        logic [MAG_W-1:0]          num_x;
        logic [MAG_W-1:0]          num_y;
        logic [DEN_W-1:0]          den;
        logic                      neg_x;
        logic                      neg_y;
        logic                      zero;
        logic signed [DEPTH_W-1:0] depth;
    } t_ppp_div_in;

    typedef struct packed {
        logic [MAG_W-1:0]          quot_x;
        logic [MAG_W-1:0]          quot_y;
        logic                      neg_x;
        logic                      neg_y;
        logic                      zero;
        logic signed [DEPTH_W-1:0] depth;
    } t_ppp_div_out;

    function automatic logic signed [DEPTH_W-1:0] sat_depth(
        input logic signed [CAM_W-1:0] v
    );
        logic signed [63:0] w;
        logic signed [DEPTH_W-1:0] res;
        w = 64'(v);
        if (w > 64'sd8388607) begin
            res = DEPTH_W'(64'sd8388607);
        end else if (w < -64'sd8388608) begin
            res = DEPTH_W'(-64'sd8388608);
        end else begin
            res = w[DEPTH_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/ppp_xform.sv =====
module ppp_xform (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ppp_pkg::t_ppp_point  i_point,
    input  ppp_pkg::t_ppp_cfg    i_cfg,
    output logic                 o_valid,
    output ppp_pkg::t_ppp_div_in o_div
);

    localparam int CW = ppp_pkg::COORD_W;
    localparam int DW = ppp_pkg::D_W;
    localparam int PW = ppp_pkg::PROD_W;
    localparam int AW = ppp_pkg::ACC_W;
    localparam int KW = ppp_pkg::CAM_W;
    localparam int NW = ppp_pkg::NUM_W;
    localparam int RW = ppp_pkg::ROT_W;

    logic                  r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [DW-1:0]  r_d [3];
    logic signed [PW-1:0]  r_prod [3][3];
    logic signed [KW-1:0]  r_cam [3];
    logic signed [NW-1:0]  r_num_x, r_num_y;
    logic signed [KW-1:0]  r_cz;
    ppp_pkg::t_ppp_div_in  r_div;

    logic signed [CW-1:0]  n_pt [3];
    logic signed [CW-1:0]  n_cc [3];
    logic [ppp_pkg::CFG_W-1:0] n_rows [3];
    logic signed [AW-1:0]  n_acc [3];
    logic signed [NW-1:0]  n_nx, n_ny;
    logic [NW-1:0]         n_ax, n_ay;
    logic [KW-1:0]         n_az;

    always_comb begin
        n_pt[0]   = i_point.point_x;
        n_pt[1]   = i_point.point_y;
        n_pt[2]   = i_point.point_z;
        n_rows[0] = i_cfg.rot_row_0;
        n_rows[1] = i_cfg.rot_row_1;
        n_rows[2] = i_cfg.rot_row_2;
        for (int i = 0; i < 3; i++) begin
            n_cc[i]  = i_cfg.cam_center[CW*i +: CW];
            n_acc[i] = AW'(r_prod[i][0]) + AW'(r_prod[i][1]) + AW'(r_prod[i][2])
                       + AW'(1 << (ppp_pkg::FRAC_SH - 1));
        end
        n_nx = NW'($signed({1'b0, i_cfg.focal_x}) * r_cam[0]) <<< 4;
        n_ny = NW'($signed({1'b0, i_cfg.focal_y}) * r_cam[1]) <<< 4;
        n_ax = r_num_x[NW-1] ? NW'(-r_num_x) : NW'(r_num_x);
        n_ay = r_num_y[NW-1] ? NW'(-r_num_y) : NW'(r_num_y);
        n_az = r_cz[KW-1] ? KW'(-r_cz) : KW'(r_cz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_d[i] <= DW'(n_pt[i]) - DW'(n_cc[i]);
            for (int c = 0; c < 3; c++) begin
                r_prod[i][c] <= PW'($signed(n_rows[i][RW*c +: RW]) * r_d[c]);
            end
            r_cam[i] <= n_acc[i][AW-1:ppp_pkg::FRAC_SH];
        end
        r_num_x     <= n_nx;
        r_num_y     <= n_ny;
        r_cz        <= r_cam[2];
        r_div.num_x <= n_ax[ppp_pkg::MAG_W-1:0];
        r_div.num_y <= n_ay[ppp_pkg::MAG_W-1:0];
        r_div.den   <= n_az;
        r_div.neg_x <= r_num_x[NW-1] ^ r_cz[KW-1];
        r_div.neg_y <= r_num_y[NW-1] ^ r_cz[KW-1];
        r_div.zero  <= (r_cz == '0);
        r_div.depth <= ppp_pkg::sat_depth(r_cz);
    end

    assign o_valid = r_v5;
    assign o_div   = r_div;

endmodule

// ===== rtl/ppp_div.sv =====
module ppp_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ppp_pkg::t_ppp_div_in  i_div,
    output logic                  o_valid,
    output ppp_pkg::t_ppp_div_out o_div
);

    localparam int MW = ppp_pkg::MAG_W;
    localparam int DW = ppp_pkg::DEN_W;

    logic [MW:0]             r_v;
    logic [MW-1:0]           r_nx   [MW+1];
    logic [MW-1:0]           r_ny   [MW+1];
    logic [MW-1:0]           r_qx   [MW+1];
    logic [MW-1:0]           r_qy   [MW+1];
    logic [DW-1:0]           r_rx   [MW+1];
    logic [DW-1:0]           r_ry   [MW+1];
    logic [DW-1:0]           r_den  [MW+1];
    logic                    r_negx [MW+1];
    logic                    r_negy [MW+1];
    logic                    r_zero [MW+1];
    logic signed [ppp_pkg::DEPTH_W-1:0] r_dep [MW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[MW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_nx[0]   <= i_div.num_x;
        r_ny[0]   <= i_div.num_y;
        r_qx[0]   <= '0;
        r_qy[0]   <= '0;
        r_rx[0]   <= '0;
        r_ry[0]   <= '0;
        r_den[0]  <= i_div.den;
        r_negx[0] <= i_div.neg_x;
        r_negy[0] <= i_div.neg_y;
        r_zero[0] <= i_div.zero;
        r_dep[0]  <= i_div.depth;
    end

    for (genvar s = 0; s < MW; s++) begin : g_stage
        logic [DW:0] n_tx, n_ty;
        logic        n_gex, n_gey;

        always_comb begin
            n_tx  = {r_rx[s], r_nx[s][MW-1]};
            n_ty  = {r_ry[s], r_ny[s][MW-1]};
            n_gex = (n_tx >= {1'b0, r_den[s]});
            n_gey = (n_ty >= {1'b0, r_den[s]});
        end

        always_ff @(posedge i_clk) begin
            r_rx[s+1]   <= n_gex ? DW'(n_tx - {1'b0, r_den[s]}) : DW'(n_tx);
            r_ry[s+1]   <= n_gey ? DW'(n_ty - {1'b0, r_den[s]}) : DW'(n_ty);
            r_nx[s+1]   <= r_nx[s] << 1;
            r_ny[s+1]   <= r_ny[s] << 1;
            r_qx[s+1]   <= {r_qx[s][MW-2:0], n_gex};
            r_qy[s+1]   <= {r_qy[s][MW-2:0], n_gey};
            r_den[s+1]  <= r_den[s];
            r_negx[s+1] <= r_negx[s];
            r_negy[s+1] <= r_negy[s];
            r_zero[s+1] <= r_zero[s];
            r_dep[s+1]  <= r_dep[s];
        end
    end

    assign o_valid      = r_v[MW];
    assign o_div.quot_x = r_qx[MW];
    assign o_div.quot_y = r_qy[MW];
    assign o_div.neg_x  = r_negx[MW];
    assign o_div.neg_y  = r_negy[MW];
    assign o_div.zero   = r_zero[MW];
    assign o_div.depth  = r_dep[MW];

    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[MW] && !r_zero[MW]) |-> (r_rx[MW] < r_den[MW]))
        else $error("x remainder not below divisor");

    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[MW] && !r_zero[MW]) |-> (r_ry[MW] < r_den[MW]))
        else $error("y remainder not below divisor");

endmodule

// ===== rtl/perspective_point_projection.sv =====
// Projects one world point per clock through a pinhole camera. The block never
// stalls: busy is held low, so a point is taken on every cycle with start high,
// and its result is shown for one cycle with o_result_strobe. The result passes
// through 48 register stages, the first of which loads at the accepting edge:
// five transform stages, a divider input stage and 41 restoring divider stages
// (one quotient bit per stage, x and y in parallel lanes), and one output stage.
// The receiver must take every result in the cycle in which it is shown.
// Configuration writes are always ready and should be made while no point is
// in flight.
module perspective_point_projection (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ppp_pkg::t_ppp_point  i_point,
    output logic                 o_result_strobe,
    output ppp_pkg::t_ppp_result o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [ppp_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [ppp_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int SW = ppp_pkg::SUM_W;

    ppp_pkg::t_ppp_cfg     r_cfg;
    ppp_pkg::t_ppp_div_in  n_div_in;
    ppp_pkg::t_ppp_div_out n_div_out;
    logic                  n_xf_valid, n_dv_valid;
    logic                  r_strobe;
    ppp_pkg::t_ppp_result  r_result;
    logic signed [SW-1:0]  n_sum_x, n_sum_y;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_row_0   <= ppp_pkg::CFG_W'(48'd16384);
            r_cfg.rot_row_1   <= ppp_pkg::CFG_W'(48'd16384 << 16);
            r_cfg.rot_row_2   <= ppp_pkg::CFG_W'(48'd16384 << 32);
            r_cfg.cam_center  <= '0;
            r_cfg.focal_x     <= ppp_pkg::FOCAL_W'(16);
            r_cfg.focal_y     <= ppp_pkg::FOCAL_W'(16);
            r_cfg.half_width  <= ppp_pkg::HALF_W'(40);
            r_cfg.half_height <= ppp_pkg::HALF_W'(12);
        end else if (i_cfg_valid) begin
            unique case (ppp_pkg::t_ppp_cfg_idx'(i_cfg_index))
                ppp_pkg::CFG_ROT_ROW_0:   r_cfg.rot_row_0  <= i_cfg_data;
                ppp_pkg::CFG_ROT_ROW_1:   r_cfg.rot_row_1  <= i_cfg_data;
                ppp_pkg::CFG_ROT_ROW_2:   r_cfg.rot_row_2  <= i_cfg_data;
                ppp_pkg::CFG_CAM_CENTER:  r_cfg.cam_center <= i_cfg_data;
                ppp_pkg::CFG_FOCAL_X:
                    r_cfg.focal_x <= i_cfg_data[ppp_pkg::FOCAL_W-1:0];
                ppp_pkg::CFG_FOCAL_Y:
                    r_cfg.focal_y <= i_cfg_data[ppp_pkg::FOCAL_W-1:0];
                ppp_pkg::CFG_HALF_WIDTH:
                    r_cfg.half_width <= i_cfg_data[ppp_pkg::HALF_W-1:0];
                ppp_pkg::CFG_HALF_HEIGHT:
                    r_cfg.half_height <= i_cfg_data[ppp_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    ppp_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_point (i_point),
        .i_cfg   (r_cfg),
        .o_valid (n_xf_valid),
        .o_div   (n_div_in)
    );

    ppp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_xf_valid),
        .i_div   (n_div_in),
        .o_valid (n_dv_valid),
        .o_div   (n_div_out)
    );

    always_comb begin
        logic signed [SW-1:0] qx, qy;
        qx = $signed({2'b00, n_div_out.quot_x});
        qy = $signed({2'b00, n_div_out.quot_y});
        if (n_div_out.neg_x) begin
            qx = -qx;
        end
        if (n_div_out.neg_y) begin
            qy = -qy;
        end
        n_sum_x = qx + $signed(SW'({r_cfg.half_width, 8'd0}));
        n_sum_y = qy + $signed(SW'({r_cfg.half_height, 8'd0}));
    end

    function automatic logic signed [ppp_pkg::PIX_W-1:0] sat_pix(
        input logic signed [SW-1:0] v
    );
        logic signed [63:0] w;
        logic signed [ppp_pkg::PIX_W-1:0] res;
        w = 64'(v);
        if (w > 64'sd2147483647) begin
            res = ppp_pkg::PIX_W'(64'sd2147483647);
        end else if (w < -64'sd2147483648) begin
            res = ppp_pkg::PIX_W'(-64'sd2147483648);
        end else begin
            res = w[ppp_pkg::PIX_W-1:0];
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.zero_depth <= n_div_out.zero;
        if (n_div_out.zero) begin
            r_result.pixel_x <= '0;
            r_result.pixel_y <= '0;
            r_result.depth   <= '0;
        end else begin
            r_result.pixel_x <= sat_pix(n_sum_x);
            r_result.pixel_y <= sat_pix(n_sum_y);
            r_result.depth   <= n_div_out.depth;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.zero_depth) |->
        (r_result.pixel_x == '0 && r_result.pixel_y == '0 && r_result.depth == '0))
        else $error("zero depth result carries nonzero fields");

    a_depth_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_result.zero_depth) |-> (r_result.depth != '0))
        else $error("zero depth not flagged");

    a_strobe_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_dv_valid |=> r_strobe)
        else $error("divider result dropped");

endmodule
